// ===== rtl/flc_pkg.sv =====
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and constants for the fault latch with retry cooldown.
// ----------------------------------------------------------------------------
package flc_pkg;

  // command codes carried in the input tuser
  typedef enum logic [1:0] {
    CMD_FAULT   = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_RECOVER = 2'd3
  } cmd_t;

  // register indexes on the configuration port
  localparam logic [1:0] REG_SHUTDOWN_MASK  = 2'd0;
  localparam logic [1:0] REG_COOLDOWN_TICKS = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES    = 2'd2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam int FLAGS_W    = 8;
  localparam int ZONE_W     = 8;
  localparam int COUNT_W    = 16;
  localparam int RETRY_W    = 8;
  localparam int COOLDOWN_W = 20;

  localparam logic [COUNT_W-1:0]    COUNT_MAX = '1;
  localparam logic [RETRY_W-1:0]    RETRY_MAX = '1;

  localparam logic [FLAGS_W-1:0]    RST_SHUTDOWN_MASK  = 8'd3;
  localparam logic [COOLDOWN_W-1:0] RST_COOLDOWN_TICKS = 20'd30000;
  localparam logic [RETRY_W-1:0]    RST_MAX_RETRIES    = 8'd3;

  typedef struct packed {
    logic [FLAGS_W-1:0]    shutdown_mask;
    logic [COOLDOWN_W-1:0] cooldown_ticks;
    logic [RETRY_W-1:0]    max_retries;
  } cfg_t;

  // result item, laid out exactly as out_tdata (lowest field last)
  typedef struct packed {
    logic                  fill;
    logic [COOLDOWN_W-1:0] cooldown_left;
    logic                  recover_ok;
    logic [RETRY_W-1:0]    retry_total;
    logic [COUNT_W-1:0]    fault_total;
    logic [FLAGS_W-1:0]    zone_flags;
    logic [FLAGS_W-1:0]    latched_flags;
    logic                  any_fault;
    logic                  shutdown_active;
  } result_t;

endpackage

// ===== rtl/flc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// flc_cfg_regs
// APB-style register file for shutdown mask, cooldown length and retry limit.
// ----------------------------------------------------------------------------
module flc_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [flc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [flc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [flc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output flc_pkg::cfg_t                   cfg
);
  import flc_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shutdown_mask  <= RST_SHUTDOWN_MASK;
      cfg_r.cooldown_ticks <= RST_COOLDOWN_TICKS;
      cfg_r.max_retries    <= RST_MAX_RETRIES;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SHUTDOWN_MASK:  cfg_r.shutdown_mask  <= cfg_pwdata[FLAGS_W-1:0];
        REG_COOLDOWN_TICKS: cfg_r.cooldown_ticks <= cfg_pwdata[COOLDOWN_W-1:0];
        REG_MAX_RETRIES:    cfg_r.max_retries    <= cfg_pwdata[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SHUTDOWN_MASK:  cfg_prdata = CFG_DATA_W'(cfg_r.shutdown_mask);
      REG_COOLDOWN_TICKS: cfg_prdata = CFG_DATA_W'(cfg_r.cooldown_ticks);
      REG_MAX_RETRIES:    cfg_prdata = CFG_DATA_W'(cfg_r.max_retries);
      default:            cfg_prdata = '0;
    endcase
  end

endmodule

// ===== rtl/flc_core.sv =====
// ----------------------------------------------------------------------------
// flc_core
// Protection state (flags, zone histories, counters, shutdown) and its
// single-pass update for one command.
// ----------------------------------------------------------------------------
module flc_core #(
  parameter int ZONE_COUNT  = 4,
  parameter int FAULT_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  flc_pkg::cmd_t                cmd,
  input  logic [flc_pkg::FLAGS_W-1:0]  fault_bits,
  input  logic [flc_pkg::ZONE_W-1:0]   zone,
  input  flc_pkg::cfg_t                cfg,
  output flc_pkg::result_t             result
);
  import flc_pkg::*;

  localparam int FLAG_W = (FAULT_WIDTH < FLAGS_W) ? FAULT_WIDTH : FLAGS_W;
  localparam int ZIDX_W = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

  logic [FLAG_W-1:0]     gflags_r,   gflags_nxt;
  logic [FLAG_W-1:0]     zhist_r     [ZONE_COUNT];
  logic [FLAG_W-1:0]     zhist_nxt   [ZONE_COUNT];
  logic [COUNT_W-1:0]    fcount_r,   fcount_nxt;
  logic                  sd_r,       sd_nxt;
  logic [RETRY_W-1:0]    retry_r,    retry_nxt;
  logic [COOLDOWN_W-1:0] cd_r,       cd_nxt;

  logic [FLAG_W-1:0]     bits;
  logic [ZIDX_W-1:0]     zidx;
  logic                  ok;
  logic                  try_recover;
  logic                  do_clear;

  assign bits = fault_bits[FLAG_W-1:0];

  // out-of-range zones fold onto zone 0
  always_comb begin
    if (zone < ZONE_W'(ZONE_COUNT)) zidx = zone[ZIDX_W-1:0];
    else                            zidx = '0;
  end

  always_comb begin
    gflags_nxt  = gflags_r;
    zhist_nxt   = zhist_r;
    fcount_nxt  = fcount_r;
    sd_nxt      = sd_r;
    retry_nxt   = retry_r;
    cd_nxt      = cd_r;
    ok          = 1'b0;
    try_recover = 1'b0;
    do_clear    = 1'b0;

    unique case (cmd)
      CMD_FAULT: begin
        gflags_nxt      = gflags_r | bits;
        zhist_nxt[zidx] = zhist_r[zidx] | bits;
        if (fcount_r != COUNT_MAX) fcount_nxt = fcount_r + 1'b1;
        if ((bits & cfg.shutdown_mask[FLAG_W-1:0]) != '0) begin
          sd_nxt = 1'b1;
          cd_nxt = cfg.cooldown_ticks;
          if (retry_r != RETRY_MAX) retry_nxt = retry_r + 1'b1;
        end
      end
      CMD_CLEAR: begin
        do_clear = 1'b1;
      end
      CMD_TICK: begin
        if (cd_r != '0) cd_nxt = cd_r - 1'b1;
        try_recover = 1'b1;
      end
      CMD_RECOVER: begin
        try_recover = 1'b1;
      end
      default: ;
    endcase

    // recovery sees the cooldown after this item's tick
    if (try_recover) begin
      if (!sd_r) begin
        ok = 1'b1;
      end else if (cd_nxt == '0 && retry_r <= cfg.max_retries) begin
        ok       = 1'b1;
        sd_nxt   = 1'b0;
        do_clear = 1'b1;
      end
    end

    if (do_clear) begin
      gflags_nxt = '0;
      for (int i = 0; i < ZONE_COUNT; i++) zhist_nxt[i] = '0;
      retry_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gflags_r <= '0;
      for (int i = 0; i < ZONE_COUNT; i++) zhist_r[i] <= '0;
      fcount_r <= '0;
      sd_r     <= 1'b0;
      retry_r  <= '0;
      cd_r     <= '0;
    end else if (step) begin
      gflags_r <= gflags_nxt;
      zhist_r  <= zhist_nxt;
      fcount_r <= fcount_nxt;
      sd_r     <= sd_nxt;
      retry_r  <= retry_nxt;
      cd_r     <= cd_nxt;
    end
  end

  always_comb begin
    result                 = '0;
    result.shutdown_active = sd_nxt;
    result.any_fault       = (gflags_nxt != '0);
    result.latched_flags   = FLAGS_W'(gflags_nxt);
    result.zone_flags      = FLAGS_W'(zhist_nxt[zidx]);
    result.fault_total     = fcount_nxt;
    result.retry_total     = retry_nxt;
    result.recover_ok      = ok;
    result.cooldown_left   = cd_nxt;
  end

endmodule

// ===== rtl/fault_latch_with_retry_cooldown.sv =====
// ----------------------------------------------------------------------------
// fault_latch_with_retry_cooldown
// Hiccup-mode protection latch: latches fault flags, forces shutdown on
// masked faults and releases it after a cooldown with a bounded retry count.
// ----------------------------------------------------------------------------
// Each input transaction carries a command in in_tuser (report fault, clear,
// tick, recover) and the fault flags and zone in in_tdata; every command
// returns exactly one result transaction with the protection state after it.
// The block takes one transaction per clock while the output accepts: a
// transaction is captured in the input register, is applied to the state in
// a single combinational pass and lands in the output register, where it is
// offered on out_tvalid and completes at an edge with out_tready high.
// Back-pressure on the output stalls the input register, and in_tready drops
// only when both stages are full.
// Configuration (shutdown mask, cooldown length, retry limit) is written over
// the APB port at byte addresses 0, 4 and 8 and should only change while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module fault_latch_with_retry_cooldown #(
  parameter int ZONE_COUNT  = 4,
  parameter int FAULT_WIDTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // command input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,   // fault_bits[7:0], zone[15:8]
  input  logic [1:0]                      in_tuser,   // command[1:0]
  // result output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // shutdown_active[0], any_fault[1], latched_flags[9:2], zone_flags[17:10],
  // fault_total[33:18], retry_total[41:34], recover_ok[42],
  // cooldown_left[62:43], zero[63]
  output logic [63:0]                     out_tdata,
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [flc_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [flc_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [flc_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import flc_pkg::*;

  cfg_t                cfg;

  // input stage
  logic                in_valid_r;
  cmd_t                in_cmd_r;
  logic [FLAGS_W-1:0]  in_bits_r;
  logic [ZONE_W-1:0]   in_zone_r;

  // output stage
  logic                out_valid_r;
  result_t             out_data_r;
  result_t             result;

  logic                advance;
  logic                in_take;

  // item moves from input register to output register
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  flc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  flc_core #(
    .ZONE_COUNT  (ZONE_COUNT),
    .FAULT_WIDTH (FAULT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .cmd        (in_cmd_r),
    .fault_bits (in_bits_r),
    .zone       (in_zone_r),
    .cfg        (cfg),
    .result     (result)
  );

  // input register: control reset, payload loads on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r  <= cmd_t'(in_tuser);
      in_bits_r <= in_tdata[7:0];
      in_zone_r <= in_tdata[15:8];
    end
  end

  // output register holds the result until the transaction completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/flc_checker.sv =====
// ----------------------------------------------------------------------------
// flc_checker
// Port-level checks on the result stream of the fault latch.
// ----------------------------------------------------------------------------
module flc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata
);
  import flc_pkg::*;

  result_t res;
  assign res = out_tdata;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a granted recovery always leaves shutdown released
  a_recover_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.recover_ok |-> !res.shutdown_active)
    else $error("recover_ok with shutdown still active");

  // zone history is always a subset of the global flags, and any_fault matches them
  a_zone_subset: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (res.zone_flags & ~res.latched_flags) == '0 &&
                   res.any_fault == (res.latched_flags != '0))
    else $error("zone flags or any_fault inconsistent with latched flags");

endmodule

bind fault_latch_with_retry_cooldown flc_checker u_flc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
